/* sv/text_console_cursor_engine_core_assert.svh */
// Assertion macros for the text console cursor engine.
`ifndef TEXT_CONSOLE_CURSOR_ENGINE_CORE_ASSERT_SVH
`define TEXT_CONSOLE_CURSOR_ENGINE_CORE_ASSERT_SVH

`ifndef ASSERT_OFF

// Same-cycle implication, checked on every clock edge outside reset.
`define TCCE_ASSERT_IMPLIES(label, clk, rstn, pre, post) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (pre) |-> (post)) \
        else $error("same-cycle implication failed");

// Next-cycle implication, checked on every clock edge outside reset.
`define TCCE_ASSERT_NEXT(label, clk, rstn, pre, post) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (pre) |=> (post)) \
        else $error("next-cycle implication failed");

`else

`define TCCE_ASSERT_IMPLIES(label, clk, rstn, pre, post)
`define TCCE_ASSERT_NEXT(label, clk, rstn, pre, post)

`endif

`endif

/* sv/tcce_pkg.sv */
// Types, codes and microprogram of the text console cursor engine.
`timescale 1ns / 1ps

package tcce_pkg;

    // Operation codes carried in the input tuser.
    localparam logic [1:0] OP_PUT   = 2'd0;
    localparam logic [1:0] OP_CLEAR = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;

    // Control characters handled by put, and the space used for blanking.
    localparam logic [7:0] CH_BS    = 8'd8;
    localparam logic [7:0] CH_TAB   = 8'd9;
    localparam logic [7:0] CH_NL    = 8'd10;
    localparam logic [7:0] CH_CR    = 8'd13;
    localparam logic [7:0] CH_SPACE = 8'd32;

    // Field widths and fixed values.
    localparam int          CELL_INDEX_W = 11;
    localparam int          POS_W        = 11;
    localparam int          TAB_STOP     = 8;
    localparam logic [7:0]  ATTR_RESET   = 8'h07;
    localparam logic [15:0] RESET_BLANK  = 16'h0720;

    // Microprogram steps.
    typedef enum logic [3:0] {
        ST_RST,
        ST_RFILL,
        ST_IDLE,
        ST_PUTC,
        ST_CTRL,
        ST_CLR,
        ST_FILL,
        ST_READ,
        ST_RDV,
        ST_SCP,
        ST_SCL,
        ST_SCT,
        ST_EMIT
    } step_t;

    // Jump conditions.
    typedef enum logic [2:0] {
        C_ALWAYS,
        C_DISPATCH,
        C_LAST,
        C_SCROLL,
        C_OUT_FREE
    } cond_t;

    // Cell counter operations.
    typedef enum logic [2:0] {
        CNT_HOLD,
        CNT_ZERO,
        CNT_COLS,
        CNT_ROWB,
        CNT_INC
    } cnt_op_t;

    // Cell store write sources.
    typedef enum logic [2:0] {
        WR_NONE,
        WR_CHAR,
        WR_RBLANK,
        WR_BLANK,
        WR_COPY
    } wr_sel_t;

    // Cell store read addresses.
    typedef enum logic [1:0] {
        RD_NONE,
        RD_IDX,
        RD_CNT
    } rd_sel_t;

    // Cursor operations.
    typedef enum logic [1:0] {
        CUR_HOLD,
        CUR_PUT,
        CUR_HOME
    } cur_op_t;

    // One control word of the microprogram.
    typedef struct packed {
        logic    ready;
        cond_t   cond;
        step_t   jmp;
        step_t   nxt;
        cnt_op_t cnt_op;
        wr_sel_t wr_sel;
        rd_sel_t rd_sel;
        cur_op_t cur_op;
        logic    val_load;
        logic    emit;
    } ctrl_t;

    // Status from the datapath that the sequencer branches on.
    typedef struct packed {
        logic  in_valid;
        logic  cnt_last;
        logic  scroll;
        logic  out_free;
        step_t dispatch;
    } seq_stat_t;

    // Entry step for an accepted item.
    function automatic step_t dispatch_step(input logic [1:0] opcode, input logic [7:0] ch);
        step_t s;
        case (opcode)
            OP_PUT:   s = (ch inside {CH_BS, CH_TAB, CH_NL, CH_CR}) ? ST_CTRL : ST_PUTC;
            OP_CLEAR: s = ST_CLR;
            OP_READ:  s = ST_READ;
            default:  s = ST_EMIT;
        endcase
        return s;
    endfunction

    // The microprogram: one control word per step.
    function automatic ctrl_t ucode(input step_t s);
        ctrl_t w;
        w.ready    = 1'b0;
        w.cond     = C_ALWAYS;
        w.jmp      = ST_IDLE;
        w.nxt      = ST_IDLE;
        w.cnt_op   = CNT_HOLD;
        w.wr_sel   = WR_NONE;
        w.rd_sel   = RD_NONE;
        w.cur_op   = CUR_HOLD;
        w.val_load = 1'b0;
        w.emit     = 1'b0;
        case (s)
            ST_RST: begin
                w.cnt_op = CNT_ZERO;
                w.jmp    = ST_RFILL;
            end
            ST_RFILL: begin
                w.wr_sel = WR_RBLANK;
                w.cnt_op = CNT_INC;
                w.cond   = C_LAST;
                w.jmp    = ST_IDLE;
                w.nxt    = ST_RFILL;
            end
            ST_IDLE: begin
                w.ready = 1'b1;
                w.cond  = C_DISPATCH;
                w.nxt   = ST_IDLE;
            end
            ST_PUTC: begin
                w.wr_sel = WR_CHAR;
                w.cur_op = CUR_PUT;
                w.cnt_op = CNT_COLS;
                w.cond   = C_SCROLL;
                w.jmp    = ST_SCP;
                w.nxt    = ST_EMIT;
            end
            ST_CTRL: begin
                w.cur_op = CUR_PUT;
                w.cnt_op = CNT_COLS;
                w.cond   = C_SCROLL;
                w.jmp    = ST_SCP;
                w.nxt    = ST_EMIT;
            end
            ST_CLR: begin
                w.cur_op = CUR_HOME;
                w.cnt_op = CNT_ZERO;
                w.jmp    = ST_FILL;
            end
            ST_FILL: begin
                w.wr_sel = WR_BLANK;
                w.cnt_op = CNT_INC;
                w.cond   = C_LAST;
                w.jmp    = ST_EMIT;
                w.nxt    = ST_FILL;
            end
            ST_READ: begin
                w.rd_sel = RD_IDX;
                w.jmp    = ST_RDV;
            end
            ST_RDV: begin
                w.val_load = 1'b1;
                w.jmp      = ST_EMIT;
            end
            ST_SCP: begin
                w.rd_sel = RD_CNT;
                w.cnt_op = CNT_INC;
                w.jmp    = ST_SCL;
            end
            ST_SCL: begin
                w.rd_sel = RD_CNT;
                w.wr_sel = WR_COPY;
                w.cnt_op = CNT_INC;
                w.cond   = C_LAST;
                w.jmp    = ST_SCT;
                w.nxt    = ST_SCL;
            end
            ST_SCT: begin
                w.wr_sel = WR_COPY;
                w.cnt_op = CNT_ROWB;
                w.jmp    = ST_FILL;
            end
            ST_EMIT: begin
                w.emit = 1'b1;
                w.cond = C_OUT_FREE;
                w.jmp  = ST_IDLE;
                w.nxt  = ST_EMIT;
            end
            default: begin
                w.jmp = ST_RST;
            end
        endcase
        return w;
    endfunction

endpackage

/* sv/tcce_seq.sv */
// Microprogram sequencer: step counter, control store and conditional jumps.
`timescale 1ns / 1ps

module tcce_seq
    import tcce_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  seq_stat_t stat,
    output ctrl_t     ctrl,
    output logic      fire
);

    step_t upc_reg;
    step_t upc_next;

    // Step counter.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            upc_reg <= ST_RST;
        end else begin
            upc_reg <= upc_next;
        end
    end

    // Control word fetch and branch resolution.
    always_comb begin
        ctrl = ucode(upc_reg);
        case (ctrl.cond)
            C_ALWAYS:   fire = 1'b1;
            C_DISPATCH: fire = stat.in_valid;
            C_LAST:     fire = stat.cnt_last;
            C_SCROLL:   fire = stat.scroll;
            C_OUT_FREE: fire = stat.out_free;
            default:    fire = 1'b0;
        endcase
        if (!fire) begin
            upc_next = ctrl.nxt;
        end else if (ctrl.cond == C_DISPATCH) begin
            upc_next = stat.dispatch;
        end else begin
            upc_next = ctrl.jmp;
        end
    end

endmodule

/* sv/text_console_cursor_engine_core.sv */
// Top level of the text console cursor engine: datapath, cell store and sequencer.
`timescale 1ns / 1ps
`include "text_console_cursor_engine_core_assert.svh"

// Character-cell text console with a ROWS x COLUMNS cell store and a cursor. One
// operation is in work at a time and each gives exactly one result transfer carrying
// the linear cursor position. A printable character passes from its input transfer
// to its result through accept, cell write with cursor update and result register; a
// control code through accept, cursor update and result register; a cell read through
// accept, cell read, value load and result register. Clearing the screen and the scroll
// of a put that moves past the last row are long operations, set by the single write
// port of the cell store, which moves or blanks one cell per cycle. After reset the
// store is blanked to 0x0720 in a pass during which no input transfer is taken;
// configuration writes are taken at any time. A result that the downstream side has
// not taken holds the engine in its result step.
module text_console_cursor_engine_core
    import tcce_pkg::*;
#(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
)
(
    input  logic        aclk,
    input  logic        aresetn,
    // Input channel.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // [7:0] char_code, [18:8] cell_index, rest zero
    input  logic [1:0]  s_tuser,   // [1:0] opcode
    // Result channel.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [10:0] cursor_position, [26:11] cell_value, rest zero
    // Color attribute register.
    input  logic        cfg_we,
    input  logic [7:0]  cfg_wdata
);

    localparam int CELL_COUNT = ROWS * COLUMNS;
    localparam int ADDR_W     = $clog2(CELL_COUNT);
    localparam int CNT_W      = $clog2(CELL_COUNT + 1);
    localparam int COL_W      = $clog2(COLUMNS);
    localparam int ROW_W      = $clog2(ROWS);
    localparam int ROW_BASE   = (ROWS - 1) * COLUMNS;
    localparam int IDXW_W     = ADDR_W + CELL_INDEX_W;

    ctrl_t     ctrl;
    logic      fire;
    seq_stat_t stat;

    logic [7:0]              attr_reg;
    logic [7:0]              ch_reg;
    logic [CELL_INDEX_W-1:0] idx_reg;
    logic [COL_W-1:0]        col_reg, col_next;
    logic [ROW_W-1:0]        row_reg, row_next;
    logic [CNT_W-1:0]        cnt_reg, cnt_next;
    logic [15:0]             val_reg;
    logic [15:0]             rdata_reg;
    logic                    m_tvalid_reg;
    logic [31:0]             m_tdata_reg;

    logic                    accept;
    logic                    out_free;
    logic [COL_W:0]          col_ext;
    logic [ROW_W:0]          row_ext;
    logic [COL_W:0]          col_step;
    logic                    row_inc;
    logic                    wrap;
    logic                    scroll;
    logic [COL_W-1:0]        col_put;
    logic [ROW_W-1:0]        row_put;
    logic [ADDR_W-1:0]       pos;
    logic [ADDR_W+POS_W-1:0] pos_wide;
    logic [IDXW_W-1:0]       idx_wide;
    logic                    idx_in_range;
    logic [CNT_W-1:0]        copy_addr;

    logic                    mem_we;
    logic [ADDR_W-1:0]       mem_waddr;
    logic [15:0]             mem_wdata;
    logic                    mem_re;
    logic [ADDR_W-1:0]       mem_raddr;
    logic [15:0]             mem [CELL_COUNT];

    // Sequencer.
    tcce_seq u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .stat    (stat),
        .ctrl    (ctrl),
        .fire    (fire)
    );

    assign s_tready = ctrl.ready;
    assign accept   = s_tvalid && ctrl.ready;
    assign out_free = !m_tvalid_reg || m_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // Cursor update for one put: control codes, advance and wrap at the line end.
    always_comb begin
        col_ext = {1'b0, col_reg};
        row_ext = {1'b0, row_reg};
        row_inc = 1'b0;
        case (ch_reg)
            CH_NL: begin
                col_step = '0;
                row_inc  = 1'b1;
            end
            CH_CR: begin
                col_step = '0;
            end
            CH_TAB: begin
                col_step = (col_ext + (COL_W + 1)'(TAB_STOP)) & ~((COL_W + 1)'(TAB_STOP - 1));
            end
            CH_BS: begin
                col_step = (col_reg != '0) ? col_ext - (COL_W + 1)'(1) : col_ext;
            end
            default: begin
                col_step = col_ext + (COL_W + 1)'(1);
            end
        endcase
        wrap    = col_step >= (COL_W + 1)'(COLUMNS);
        col_put = wrap ? '0 : col_step[COL_W-1:0];
        scroll  = (row_inc || wrap) && (row_reg == ROW_W'(ROWS - 1));
        // A scroll leaves the cursor on the last row.
        row_put = ((row_inc || wrap) && !scroll) ? row_reg + ROW_W'(1) : row_reg;
    end

    // Cursor register next values.
    always_comb begin
        case (ctrl.cur_op)
            CUR_PUT: begin
                col_next = col_put;
                row_next = row_put;
            end
            CUR_HOME: begin
                col_next = '0;
                row_next = '0;
            end
            default: begin
                col_next = col_reg;
                row_next = row_reg;
            end
        endcase
    end

    // Linear cursor position and read index range.
    assign pos          = ADDR_W'(ADDR_W'(row_reg) * ADDR_W'(COLUMNS)) + ADDR_W'(col_reg);
    assign pos_wide     = (ADDR_W + POS_W)'(pos);
    assign idx_wide     = IDXW_W'(idx_reg);
    assign idx_in_range = idx_wide < IDXW_W'(CELL_COUNT);
    assign copy_addr    = cnt_reg - CNT_W'(COLUMNS + 1);

    // Cell counter next value.
    always_comb begin
        case (ctrl.cnt_op)
            CNT_ZERO: cnt_next = '0;
            CNT_COLS: cnt_next = CNT_W'(COLUMNS);
            CNT_ROWB: cnt_next = CNT_W'(ROW_BASE);
            CNT_INC:  cnt_next = cnt_reg + CNT_W'(1);
            default:  cnt_next = cnt_reg;
        endcase
    end

    // Status for the sequencer.
    always_comb begin
        stat.in_valid = s_tvalid;
        stat.cnt_last = cnt_reg == CNT_W'(CELL_COUNT - 1);
        stat.scroll   = scroll;
        stat.out_free = out_free;
        stat.dispatch = dispatch_step(s_tuser, s_tdata[7:0]);
    end

    // Cell store write port selection.
    always_comb begin
        mem_we    = 1'b1;
        mem_waddr = cnt_reg[ADDR_W-1:0];
        mem_wdata = rdata_reg;
        case (ctrl.wr_sel)
            WR_CHAR: begin
                mem_waddr = pos;
                mem_wdata = {attr_reg, ch_reg};
            end
            WR_RBLANK: begin
                mem_wdata = RESET_BLANK;
            end
            WR_BLANK: begin
                mem_wdata = {attr_reg, CH_SPACE};
            end
            WR_COPY: begin
                mem_waddr = copy_addr[ADDR_W-1:0];
            end
            default: begin
                mem_we = 1'b0;
            end
        endcase
    end

    // Cell store read port selection.
    always_comb begin
        case (ctrl.rd_sel)
            RD_IDX: begin
                mem_re    = idx_in_range;
                mem_raddr = idx_wide[ADDR_W-1:0];
            end
            RD_CNT: begin
                mem_re    = 1'b1;
                mem_raddr = cnt_reg[ADDR_W-1:0];
            end
            default: begin
                mem_re    = 1'b0;
                mem_raddr = cnt_reg[ADDR_W-1:0];
            end
        endcase
    end

    // Cell store write.
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
    end

    // Cell store registered read.
    always_ff @(posedge aclk) begin
        if (mem_re) begin
            rdata_reg <= mem[mem_raddr];
        end
    end

    // Control registers: cursor, counter, attribute and result valid.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            attr_reg     <= ATTR_RESET;
            col_reg      <= '0;
            row_reg      <= '0;
            cnt_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (cfg_we) begin
                attr_reg <= cfg_wdata;
            end
            col_reg <= col_next;
            row_reg <= row_next;
            cnt_reg <= cnt_next;
            if (ctrl.emit && fire) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // Payload registers: latched input fields, read value and result data.
    always_ff @(posedge aclk) begin
        if (accept) begin
            ch_reg  <= s_tdata[7:0];
            idx_reg <= s_tdata[18:8];
            val_reg <= '0;
        end else if (ctrl.val_load) begin
            val_reg <= idx_in_range ? rdata_reg : '0;
        end
        if (ctrl.emit && fire) begin
            m_tdata_reg <= {5'b0, val_reg, pos_wide[POS_W-1:0]};
        end
    end

    // The cursor stays on the screen whenever a new item may enter.
    `TCCE_ASSERT_IMPLIES(a_cursor_on_screen, aclk, aresetn, s_tready, (col_ext < (COL_W + 1)'(COLUMNS)) && (row_ext < (ROW_W + 1)'(ROWS)))
    // An accepted item closes the input until its result is produced.
    `TCCE_ASSERT_NEXT(a_one_item_in_work, aclk, aresetn, s_tvalid && s_tready, !s_tready)
    // The scroll copy always writes a full row behind its read pointer.
    `TCCE_ASSERT_IMPLIES(a_copy_behind_read, aclk, aresetn, ctrl.wr_sel == WR_COPY, cnt_reg > CNT_W'(COLUMNS))

endmodule
